@@ src/rplt_pkg.sv @@
// Package for the route prefix lookup table: table depth, derived widths,
// status and operation codes, and the route and search token types.
// Depends on nothing; every other file of the block imports it.
package rplt_pkg;

	localparam int ROUTE_DEPTH = 64;
	localparam int IDX_W = (ROUTE_DEPTH > 1) ? $clog2(ROUTE_DEPTH) : 1;
	localparam int CNT_W = $clog2(ROUTE_DEPTH + 1);
	localparam int ENTRY_INDEX_W = 6;

	localparam logic [1:0] FUNC_ADD = 2'd0;
	localparam logic [1:0] FUNC_REMOVE = 2'd1;
	localparam logic [1:0] FUNC_LOOKUP = 2'd2;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_FULL = 2'd1;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

	typedef enum logic {
		S_IDLE,
		S_SCAN
	} state_t;

	typedef struct packed {
		logic [31:0] dest;
		logic [31:0] mask;
		logic [31:0] hop;
		logic [31:0] metric;
	} route_t;

	// Search token that walks the cell row, one cell per cycle.
	typedef struct packed {
		logic             valid;
		logic             is_remove;
		logic [31:0]      key;
		logic [31:0]      key_mask;
		logic             found;
		logic [IDX_W-1:0] best_idx;
		logic [31:0]      win_mask;
		logic [31:0]      win_metric;
		logic [31:0]      best_hop;
	} token_t;

endpackage

@@ src/route_prefix_lookup_table.sv @@
// Route prefix lookup table: a row of ROUTE_DEPTH cells, one route per cell.
// Add and unused operations answer in the cycle after the input transfer.
// Lookup and remove send a token down the cell row, one cell per cycle, and
// answer when it leaves the last cell; no new input is taken until the answer
// is registered and can be drained. Reset empties the table.
module route_prefix_lookup_table (
	input  logic         clk,
	input  logic         arst_n,
	// Input channel.
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // dest_addr, prefix_mask, next_hop, route_metric
	input  logic [1:0]   s_tuser,   // func
	// Result channel.
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [39:0]  m_tdata,   // entry_index, matched_next_hop, zero pad
	output logic [1:0]   m_tuser    // status
);
	import rplt_pkg::*;

	state_t state_q;
	state_t state_next;

	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;
	logic [1:0]       out_status_q;
	logic [ENTRY_INDEX_W-1:0] out_index_q;
	logic [31:0]      out_hop_q;

	logic             in_xfer;
	logic [1:0]       func;
	route_t           in_route;
	logic             table_full;
	logic             add_ok;
	logic             scan_done;
	logic             remove_commit;

	token_t tok_head;
	token_t tok [0:ROUTE_DEPTH];
	route_t ent [0:ROUTE_DEPTH-1];

	assign func = s_tuser;
	assign in_route.dest = s_tdata[31:0];
	assign in_route.mask = s_tdata[63:32];
	assign in_route.hop = s_tdata[95:64];
	assign in_route.metric = s_tdata[127:96];

	// The output register may be drained in the same cycle that a new
	// transfer is taken.
	assign s_tready = (state_q == S_IDLE) && (!out_valid_q || m_tready);
	assign in_xfer = s_tvalid && s_tready;
	assign table_full = (count_q == CNT_W'(ROUTE_DEPTH));
	assign add_ok = in_xfer && (func == FUNC_ADD) && !table_full;

	// The token enters cell zero directly from the input transfer.
	always_comb begin
		tok_head.valid = in_xfer && ((func == FUNC_REMOVE) || (func == FUNC_LOOKUP));
		tok_head.is_remove = (func == FUNC_REMOVE);
		tok_head.key = in_route.dest;
		tok_head.key_mask = in_route.mask;
		tok_head.found = 1'b0;
		tok_head.best_idx = '0;
		tok_head.win_mask = '0;
		tok_head.win_metric = '0;
		tok_head.best_hop = '0;
	end

	assign tok[0] = tok_head;

	assign scan_done = tok[ROUTE_DEPTH].valid;
	assign remove_commit = scan_done && tok[ROUTE_DEPTH].is_remove && tok[ROUTE_DEPTH].found;

	// Cell row. On a committed remove, every cell at or above the removed
	// index takes its upper neighbor's route; the top cell keeps its own.
	for (genvar k = 0; k < ROUTE_DEPTH; k++) begin : g_cell
		route_t nbr;
		if (k == ROUTE_DEPTH - 1) begin : g_top
			assign nbr = ent[k];
		end else begin : g_mid
			assign nbr = ent[k+1];
		end
		rplt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cell_idx  (IDX_W'(k)),
			.live      (CNT_W'(k) < count_q),
			.wr_en     (add_ok && (CNT_W'(k) == count_q)),
			.wr_route  (in_route),
			.shift_en  (remove_commit && (IDX_W'(k) >= tok[ROUTE_DEPTH].best_idx)),
			.nbr_route (nbr),
			.tok_in    (tok[k]),
			.tok_out   (tok[k+1]),
			.route     (ent[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (tok[0].valid) begin
					state_next = S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_done) begin
					state_next = S_IDLE;
				end
			end
			default: state_next = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (add_ok) begin
			count_q <= count_q + CNT_W'(1);
		end else if (remove_commit) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((in_xfer && !tok[0].valid) || scan_done) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload: add and unused codes answer at once, searches at the
	// end of the row.
	always_ff @(posedge clk) begin
		if (scan_done) begin
			out_status_q <= tok[ROUTE_DEPTH].found ? STATUS_OK : STATUS_NOT_FOUND;
			out_index_q <= tok[ROUTE_DEPTH].found ?
				ENTRY_INDEX_W'(tok[ROUTE_DEPTH].best_idx) : '0;
			out_hop_q <= (tok[ROUTE_DEPTH].found && !tok[ROUTE_DEPTH].is_remove) ?
				tok[ROUTE_DEPTH].best_hop : 32'd0;
		end else if (in_xfer && !tok[0].valid) begin
			out_hop_q <= 32'd0;
			if (func == FUNC_ADD) begin
				out_status_q <= table_full ? STATUS_FULL : STATUS_OK;
				out_index_q <= table_full ? '0 : ENTRY_INDEX_W'(count_q);
			end else begin
				out_status_q <= STATUS_NOT_FOUND;
				out_index_q <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser = out_status_q;
	assign m_tdata = {2'b00, out_hop_q, out_index_q};

`ifndef SYNTHESIS
	a_token_only_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_done |-> (state_q == S_SCAN))
		else $error("search token left the row outside a scan");
	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ROUTE_DEPTH))
		else $error("route count above table depth");
	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		add_ok |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("accepted add did not grow the table");
	a_no_result_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> (out_valid_q && $stable(out_status_q)))
		else $error("pending result overwritten");
`endif

endmodule

@@ src/rplt_cell.sv @@
// One cell of the route table: holds a single route and updates the search
// token that passes through it. Depends on rplt_pkg.
module rplt_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [rplt_pkg::IDX_W-1:0] cell_idx,
	input  logic                  live,
	input  logic                  wr_en,
	input  rplt_pkg::route_t      wr_route,
	input  logic                  shift_en,
	input  rplt_pkg::route_t      nbr_route,
	input  rplt_pkg::token_t      tok_in,
	output rplt_pkg::token_t      tok_out,
	output rplt_pkg::route_t      route
);
	import rplt_pkg::*;

	route_t route_q;
	token_t tok_q;
	logic   valid_q;
	token_t tok_next;
	logic   remove_hit;
	logic   prefix_hit;
	logic   better;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			route_q <= wr_route;
		end else if (shift_en) begin
			route_q <= nbr_route;
		end
	end

	always_comb begin
		remove_hit = tok_in.is_remove && live && !tok_in.found &&
			(route_q.dest == tok_in.key) && (route_q.mask == tok_in.key_mask);
		prefix_hit = !tok_in.is_remove && live &&
			(((tok_in.key ^ route_q.dest) & route_q.mask) == 32'd0);
		better = !tok_in.found || (route_q.mask > tok_in.win_mask) ||
			((route_q.mask == tok_in.win_mask) && (route_q.metric < tok_in.win_metric));
		tok_next = tok_in;
		if (remove_hit || (prefix_hit && better)) begin
			tok_next.found = 1'b1;
			tok_next.best_idx = cell_idx;
			tok_next.win_mask = route_q.mask;
			tok_next.win_metric = route_q.metric;
			tok_next.best_hop = route_q.hop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_next;
	end

	// Only the valid bit of the token is reset; the payload follows it.
	always_comb begin
		tok_out = tok_q;
		tok_out.valid = valid_q;
	end

	assign route = route_q;

endmodule
